FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL. Defining SYNTH removes
// them from the build.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

FILE: rtl/smm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square matrix multiply package
// Shared widths, codes, item types and state encoding.
// ----------------------------------------------------------------------------
package smm_pkg;

  // Default largest matrix dimension held in the stores.
  parameter int MaxDim = 8;

  // Field widths.
  parameter int DataW  = 32;
  parameter int IdxW   = 3;
  parameter int KindW  = 2;
  parameter int SizeW  = 2;

  // Configuration port.
  parameter int ApbAddrW = 3;
  parameter int ApbDataW = 32;
  localparam logic [0:0] RegSizeLog2 = 1'b0;
  localparam logic [SizeW-1:0] SizeLog2Reset = 2'd3;

  // Input item kinds.
  typedef enum logic [KindW-1:0] {
    KindLoadA   = 2'd0,
    KindLoadB   = 2'd1,
    KindCompute = 2'd2
  } kind_e;

  // Input transaction payload.
  typedef struct packed {
    logic [KindW-1:0]        kind;
    logic [IdxW-1:0]         row;
    logic [IdxW-1:0]         col;
    logic signed [DataW-1:0] value;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic [IdxW-1:0]         out_row;
    logic [IdxW-1:0]         out_col;
    logic signed [DataW-1:0] product;
    logic                    last;
  } out_item_t;

  // Compute sequencer states.
  typedef enum logic [1:0] {
    StIdle  = 2'd0,
    StRun   = 2'd1,
    StDrain = 2'd2,
    StPush  = 2'd3
  } seq_state_e;

endpackage

FILE: rtl/smm_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Streaming channel
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface smm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/smm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module smm_ram
  import smm_pkg::*;
#(
  parameter int WIDTH = DataW,
  parameter int DEPTH = MaxDim * MaxDim,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/smm_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration register block
// APB-style port holding the size_log2 register.
// ----------------------------------------------------------------------------
module smm_cfg
  import smm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output logic [SizeW-1:0]    size_log2_o
);

  logic [SizeW-1:0] size_log2_q, size_log2_d;
  logic             sel_size;

  // Register decode by word index.
  assign sel_size = (paddr[ApbAddrW-1:2] == RegSizeLog2);

  // Write on the access phase.
  always_comb begin
    size_log2_d = size_log2_q;
    if (psel && penable && pwrite && pready && sel_size) begin
      size_log2_d = pwdata[SizeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_log2_q <= SizeLog2Reset;
    end else begin
      size_log2_q <= size_log2_d;
    end
  end

  // Read back.
  assign prdata      = sel_size ? {{(ApbDataW-SizeW){1'b0}}, size_log2_q} : '0;
  assign pready      = 1'b1;
  assign size_log2_o = size_log2_q;

endmodule

FILE: rtl/smm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply core
// Holds both operand stores and walks the product one multiply-accumulate
// per cycle while in the run state, one product element at a time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smm_core
  import smm_pkg::*;
#(
  parameter int MAX_DIM = MaxDim
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SizeW-1:0] size_log2_i,
  smm_stream_if.sink       in_i,
  smm_stream_if.source     out_o
);

  localparam int Depth   = MAX_DIM * MAX_DIM;
  localparam int AW      = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int MaxLogI = $clog2(MAX_DIM + 1) - 1;
  localparam logic [SizeW-1:0] MaxLog = (MaxLogI > 3) ? 2'd3 : SizeW'(MaxLogI);

  seq_state_e       state_q, state_d;
  logic [IdxW-1:0]  i_q, i_d, j_q, j_d, k_q, k_d, lim_q, lim_d;
  logic [IdxW-1:0]  lim_w;
  logic [SizeW-1:0] dim_log;
  logic             v1_q, v2_q;
  logic             issue, push, clr_acc, slot_free;
  logic             accept, in_range;
  logic             we_a, we_b;
  logic [AW-1:0]    waddr, raddr_a, raddr_b;
  logic [DataW-1:0] rdata_a, rdata_b, prod_d, prod_q, acc_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q;

  // Dimension in use, capped by the store size.
  assign dim_log = (size_log2_i > MaxLog) ? MaxLog : size_log2_i;
  assign lim_w   = IdxW'((4'd1 << dim_log) - 4'd1);

  // Input transaction and load decode.
  assign in_i.ready = (state_q == StIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign in_range   = (int'(in_i.data.row) < MAX_DIM) && (int'(in_i.data.col) < MAX_DIM);
  assign waddr      = AW'(int'(in_i.data.row) * MAX_DIM + int'(in_i.data.col));

  always_comb begin
    we_a = 1'b0;
    we_b = 1'b0;
    case (in_i.data.kind)
      KindLoadA: we_a = accept && in_range;
      KindLoadB: we_b = accept && in_range;
      default: begin
      end
    endcase
  end

  // Read addresses for the current term of the dot product.
  assign raddr_a = AW'(int'(i_q) * MAX_DIM + int'(k_q));
  assign raddr_b = AW'(int'(k_q) * MAX_DIM + int'(j_q));

  smm_ram #(.WIDTH(DataW), .DEPTH(Depth)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (in_i.data.value),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  smm_ram #(.WIDTH(DataW), .DEPTH(Depth)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (in_i.data.value),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  assign slot_free = !out_valid_q || out_o.ready;

  // Sequencer: issue the terms of one element, drain, then hand it out.
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    lim_d   = lim_q;
    issue   = 1'b0;
    push    = 1'b0;
    clr_acc = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept && (in_i.data.kind == KindCompute)) begin
          state_d = StRun;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          lim_d   = lim_w;
          clr_acc = 1'b1;
        end
      end
      StRun: begin
        issue = 1'b1;
        if (k_q == lim_q) begin
          k_d     = '0;
          state_d = StDrain;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      StDrain: begin
        if (!v1_q && !v2_q) begin
          state_d = StPush;
        end
      end
      StPush: begin
        if (slot_free) begin
          push    = 1'b1;
          clr_acc = 1'b1;
          if (j_q == lim_q) begin
            j_d = '0;
            if (i_q == lim_q) begin
              state_d = StIdle;
            end else begin
              i_d     = i_q + 1'b1;
              state_d = StRun;
            end
          end else begin
            j_d     = j_q + 1'b1;
            state_d = StRun;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output register next state.
  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      lim_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      lim_q       <= lim_d;
      v1_q        <= issue;
      v2_q        <= v1_q;
      out_valid_q <= out_valid_d;
    end
  end

  // Multiply, then accumulate, each behind a register. Both wrap at 32 bits.
  assign prod_d = rdata_a * rdata_b;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (clr_acc) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + prod_q;
    end
    if (push) begin
      out_q.out_row <= i_q;
      out_q.out_col <= j_q;
      out_q.product <= acc_q;
      out_q.last    <= (i_q == lim_q) && (j_q == lim_q);
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Checks on the sequencer.
  `ASSERT_ALWAYS(a_read_from_run, clk_i, rst_ni, v1_q |-> $past(state_q) == StRun, "read issued outside the run state")
  `ASSERT_NEVER(a_load_while_busy, clk_i, rst_ni, (we_a || we_b) && (state_q != StIdle), "store written during a compute")
  `ASSERT_ALWAYS(a_push_pipe_empty, clk_i, rst_ni, (state_q == StPush) |-> (!v1_q && !v2_q), "element handed out with terms in flight")
  `ASSERT_ALWAYS(a_index_bound, clk_i, rst_ni, (state_q == StRun) |-> (k_q <= lim_q && i_q <= lim_q && j_q <= lim_q), "index beyond the dimension in use")

endmodule

FILE: rtl/square_matrix_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square matrix multiply
// Loads two square matrices element by element and, on a compute
// transaction, returns their product in row-major order.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake                  Payload
//  in_i      in   valid/ready                kind, row, col, value
//  out_o     out  valid/ready                out_row, out_col, product, last
//  APB       in   psel/penable/pwrite        size_log2 at byte address 0
//
// For dimension d, each element of a compute runs d multiply-accumulate
// terms, fed by one read port per store, then drains the multiply and
// accumulate registers and hands out the sum.
// No input transaction is taken during a compute; an output stall holds the
// sequencer before it hands out the next element.
// Reset sets size_log2 to 3; the stores are not cleared.
// ----------------------------------------------------------------------------
module square_matrix_multiply
  import smm_pkg::*;
#(
  parameter int MAX_DIM = MaxDim
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  smm_stream_if.sink          in_i,
  smm_stream_if.source        out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [SizeW-1:0] size_log2;

  // Configuration register.
  smm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .size_log2_o (size_log2)
  );

  // Stores and multiply-accumulate sequencer.
  smm_core #(.MAX_DIM(MAX_DIM)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .size_log2_i (size_log2),
    .in_i        (in_i),
    .out_o       (out_o)
  );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square matrix multiply testbench
// Loads operand matrices and issues compute transactions at several
// dimensions. Every element of each product is predicted and checked in
// order. The sender works in bursts with random gaps and the receiver stalls
// on its own pattern.
// ----------------------------------------------------------------------------
module testbench;
  import smm_pkg::*;

  localparam logic [KindW-1:0]    KindUnused   = 2'd3;
  localparam logic [ApbAddrW-1:0] SizeAddr     = ApbAddrW'(4 * RegSizeLog2);
  localparam int                  RandomItems  = 270;
  localparam int                  LongHold     = 400;
  localparam int                  SettleCycles = 16;
  localparam int                  StallLimit   = 4000;

  logic clk_i;
  logic rst_ni = 1'b0;

  // APB configuration port.
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ApbAddrW-1:0] paddr   = '0;
  logic [ApbDataW-1:0] pwdata  = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  smm_stream_if #(.payload_t(in_item_t))  in_ch ();
  smm_stream_if #(.payload_t(out_item_t)) out_ch ();

  square_matrix_multiply dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock with a 2 ns period.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Stimulus bookkeeping.
  in_item_t        pending_items[$];
  int              items_queued = 0;
  int              items_taken  = 0;
  bit              a_written[MaxDim*MaxDim];
  bit              b_written[MaxDim*MaxDim];

  // Predictor state and the elements it still expects.
  logic [DataW-1:0] a_matrix[MaxDim*MaxDim];
  logic [DataW-1:0] b_matrix[MaxDim*MaxDim];
  logic [SizeW-1:0] cfg_size_log2 = SizeLog2Reset;
  out_item_t        expected_elems[$];
  int               err_count = 0;

  // Sender and receiver pacing.
  int burst_left   = 1;
  int gap_left     = 0;
  int stall_mode   = 0;
  int mode_left    = 0;
  int pattern_cnt  = 0;
  int hold_left    = 0;
  bit hold_request = 1'b0;
  bit hold_done    = 1'b0;
  bit ready_next;
  in_item_t next_item;
  logic     next_valid;
  int       idle_cycles = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  // Updates the matrices on a load and computes the product on a compute.
  task automatic apply_item(input in_item_t it);
    int               dim;
    logic [DataW-1:0] acc;
    out_item_t        elem;
    case (it.kind)
      KindLoadA: begin
        if (it.row < MaxDim && it.col < MaxDim) a_matrix[it.row * MaxDim + it.col] = it.value;
      end
      KindLoadB: begin
        if (it.row < MaxDim && it.col < MaxDim) b_matrix[it.row * MaxDim + it.col] = it.value;
      end
      KindCompute: begin
        dim = 1 << cfg_size_log2;
        while (dim > MaxDim) dim = dim >> 1;
        for (int i = 0; i < dim; i++) begin
          for (int j = 0; j < dim; j++) begin
            acc = '0;
            for (int k = 0; k < dim; k++) begin
              acc = acc + a_matrix[i * MaxDim + k] * b_matrix[k * MaxDim + j];
            end
            elem.out_row = IdxW'(i);
            elem.out_col = IdxW'(j);
            elem.product = acc;
            elem.last    = (i == dim - 1) && (j == dim - 1);
            expected_elems.push_back(elem);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Compares one product element with the oldest expected one.
  task automatic check_element(input out_item_t got);
    out_item_t want;
    if (expected_elems.size() == 0) begin
      report_mismatch("unexpected element, product", got.product, 0);
    end else begin
      want = expected_elems.pop_front();
      if (got.out_row !== want.out_row) report_mismatch("out_row", got.out_row, want.out_row);
      if (got.out_col !== want.out_col) report_mismatch("out_col", got.out_col, want.out_col);
      if (got.product !== want.product) report_mismatch("product", got.product, want.product);
      if (got.last !== want.last) report_mismatch("last", got.last, want.last);
    end
  endtask

  task automatic queue_item(input logic [KindW-1:0] kind, input int row, input int col,
                            input logic [DataW-1:0] value);
    in_item_t it;
    it.kind  = kind;
    it.row   = IdxW'(row);
    it.col   = IdxW'(col);
    it.value = value;
    if (kind == KindLoadA) a_written[row * MaxDim + col] = 1'b1;
    if (kind == KindLoadB) b_written[row * MaxDim + col] = 1'b1;
    pending_items.push_back(it);
    items_queued++;
  endtask

  function automatic logic [DataW-1:0] random_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return '0;
      4:       return DataW'($urandom_range(0, 20)) - 32'd10;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_index(input int dim);
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, MaxDim - 1);
    return $urandom_range(0, dim - 1);
  endfunction

  // Loads every entry in use that has not been written since reset.
  task automatic fill_unwritten(input int dim);
    for (int i = 0; i < dim; i++) begin
      for (int j = 0; j < dim; j++) begin
        if (!a_written[i * MaxDim + j]) queue_item(KindLoadA, i, j, random_value());
        if (!b_written[i * MaxDim + j]) queue_item(KindLoadB, i, j, random_value());
      end
    end
  endtask

  // Waits until every item is taken and every element has arrived.
  task automatic wait_for_drain();
    while (items_taken != items_queued || expected_elems.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Writes size_log2 over APB, then reads it back.
  task automatic write_size_log2(input logic [SizeW-1:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SizeAddr;
    pwdata  <= ApbDataW'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[SizeW-1:0] !== v) report_mismatch("size_log2 readback", prdata, v);
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_size_log2 = v;
    @(negedge clk_i);
  endtask

  // Stimulus: directed corner cases, then random phases.
  initial begin
    int dim;
    int phase;
    int n_loads;
    int kind_pick;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Dimension one: wrap of the product, ignored fields, unused kind.
    write_size_log2(2'd0);
    queue_item(KindLoadA, 0, 0, 32'h7fff_ffff);
    queue_item(KindLoadB, 0, 0, 32'h7fff_ffff);
    queue_item(KindCompute, 7, 7, 32'hffff_ffff);
    queue_item(KindUnused, 7, 7, 32'h8000_0000);
    queue_item(KindLoadA, 7, 7, 32'h1234_5678);
    queue_item(KindLoadA, 0, 0, 32'h8000_0000);
    queue_item(KindLoadB, 0, 0, 32'hffff_ffff);
    queue_item(KindCompute, 0, 0, '0);
    wait_for_drain();

    // Dimension two with extreme operands, two computes back to back.
    write_size_log2(2'd1);
    queue_item(KindLoadA, 0, 1, 32'hffff_ffff);
    queue_item(KindLoadA, 1, 0, 32'h8000_0000);
    queue_item(KindLoadA, 1, 1, 32'h7fff_ffff);
    queue_item(KindLoadB, 0, 1, 32'h0000_0001);
    queue_item(KindLoadB, 1, 0, 32'h7fff_ffff);
    queue_item(KindLoadB, 1, 1, 32'h0000_0000);
    queue_item(KindCompute, 5, 2, 32'h5555_aaaa);
    queue_item(KindCompute, 2, 5, 32'haaaa_5555);
    wait_for_drain();

    // Random phases, each with its own dimension.
    phase = 0;
    while (items_queued < RandomItems) begin
      if (phase == 2) write_size_log2(2'd2);
      else if (phase == 4) write_size_log2(2'd3);
      else write_size_log2(SizeW'($urandom_range(0, 2)));
      dim = 1 << cfg_size_log2;
      n_loads = $urandom_range(4, 16);
      for (int n = 0; n < n_loads; n++) begin
        kind_pick = $urandom_range(0, 8);
        if (kind_pick == 8) begin
          queue_item(KindUnused, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
        end else begin
          queue_item(kind_pick[0] ? KindLoadB : KindLoadA, pick_index(dim), pick_index(dim),
                     random_value());
        end
      end
      fill_unwritten(dim);
      queue_item(KindCompute, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
      if (phase == 2) begin
        // Output held off for a long stretch while further loads and a second compute wait.
        for (int n = 0; n < 10; n++) begin
          queue_item(KindLoadA, pick_index(dim), pick_index(dim), random_value());
        end
        queue_item(KindCompute, 0, 0, '0);
        hold_request = 1'b1;
      end else if ($urandom_range(0, 2) == 0) begin
        queue_item(KindLoadB, $urandom_range(0, dim - 1), $urandom_range(0, dim - 1),
                   random_value());
        queue_item(KindCompute, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
      end
      // The sender pauses here until every element of the phase has come.
      wait_for_drain();
      phase++;
    end

    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Driver: offers queued items in bursts separated by random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      next_valid = 1'b0;
      next_item  = in_ch.data;
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
      end else if (pending_items.size() > 0) begin
        next_item  = pending_items.pop_front();
        next_valid = 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      in_ch.valid <= next_valid;
      in_ch.data  <= next_item;
    end
  end

  // Receiver: changes its stall pattern now and then, with one long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left = mode_left - 1;
      end
      pattern_cnt = pattern_cnt + 1;
      if (hold_left > 0) begin
        hold_left  = hold_left - 1;
        ready_next = 1'b0;
      end else if (hold_request && !hold_done) begin
        hold_done  = 1'b1;
        hold_left  = LongHold - 1;
        ready_next = 1'b0;
      end else begin
        case (stall_mode)
          0:       ready_next = 1'b1;
          1:       ready_next = $urandom_range(0, 9) < 7;
          2:       ready_next = (pattern_cnt % 3) != 0;
          default: ready_next = $urandom_range(0, 9) < 3;
        endcase
      end
      out_ch.ready <= ready_next;
    end
  end

  // Monitor: predicts on each input transaction, checks each output one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        items_taken++;
        apply_item(in_ch.data);
      end
      if (out_ch.valid && out_ch.ready) check_element(out_ch.data);
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: square_matrix_multiply.f
+incdir+rtl
rtl/smm_pkg.sv
rtl/smm_stream_if.sv
rtl/smm_ram.sv
rtl/smm_cfg.sv
rtl/smm_core.sv
rtl/square_matrix_multiply.sv
dv/testbench.sv
